// ===== src/afp_pkg.sv =====
// Shared types and constants for the address field parser.
// Used by afp_core and address_field_parser; no dependencies.
package afp_pkg;

    // Default limit on digipeater addresses
    localparam int MAX_DIGIS_DEF = 8;

    // Callsign bytes per address, before the SSID byte
    localparam logic [2:0] ADDR_LEN = 3'd6;
    localparam int         C_BIT    = 7;
    localparam int         E_BIT    = 0;

    localparam int CALL_W  = 48;
    localparam int ADDR_NW = 4;
    localparam int TDATA_W = 72;

    typedef enum logic [1:0] {
        ROLE_DEST = 2'd0,
        ROLE_SRC  = 2'd1,
        ROLE_DIGI = 2'd2
    } t_role;

    typedef enum logic [1:0] {
        CR_COMMAND  = 2'd0,
        CR_RESPONSE = 2'd1,
        CR_UNKNOWN  = 2'd2
    } t_cmd_resp;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_TOO_MANY = 2'd2
    } t_status;

    typedef enum logic {
        PH_HEADER = 1'b0,
        PH_SKIP   = 1'b1
    } t_phase;

    // One parsed address result
    typedef struct packed {
        logic [CALL_W-1:0]  callsign_raw;
        logic [7:0]         ssid_byte;
        t_role              role;
        logic [2:0]         digi_index;
        t_cmd_resp          cmd_resp;
        logic               header_done;
        logic [ADDR_NW-1:0] address_count;
        t_status            status;
    } t_result;

endpackage

// ===== src/afp_core.sv =====
// Per-byte header parser: state registers and result logic for one word.
// Depends on afp_pkg.
module afp_core #(
    parameter int MAX_DIGIS = afp_pkg::MAX_DIGIS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_frame_end,
    output logic              o_res_valid,
    output afp_pkg::t_result  o_res
);

    localparam logic [afp_pkg::ADDR_NW-1:0] LAST_ADDR =
        afp_pkg::ADDR_NW'(MAX_DIGIS + 1);

    logic [2:0]                  r_byte_position, n_byte_position;
    logic [afp_pkg::ADDR_NW-1:0] r_address_number, n_address_number;
    logic [afp_pkg::CALL_W-1:0]  r_callsign_shift, n_callsign_shift;
    logic                        r_dest_c_bit, n_dest_c_bit;
    afp_pkg::t_cmd_resp          r_cmd_resp_held, n_cmd_resp_held;
    afp_pkg::t_phase             r_phase, n_phase;

    logic                        ssid_word;
    logic                        e_bit;
    logic [afp_pkg::CALL_W-1:0]  shifted;
    afp_pkg::t_cmd_resp          src_cr;
    logic                        done;
    logic                        too_many;

    // Shared decode of the current word
    assign ssid_word = (r_byte_position == afp_pkg::ADDR_LEN);
    assign e_bit     = i_data_byte[afp_pkg::E_BIT];
    assign shifted   = {r_callsign_shift[afp_pkg::CALL_W-9:0], i_data_byte};
    assign done      = (r_address_number != '0) && e_bit;
    // Last allowed digipeater without the extension bit
    assign too_many  = (r_address_number == LAST_ADDR) && !e_bit;

    // Command/response from the two C bits
    always_comb begin
        if (i_data_byte[afp_pkg::C_BIT] == r_dest_c_bit) begin
            src_cr = afp_pkg::CR_UNKNOWN;
        end else if (i_data_byte[afp_pkg::C_BIT]) begin
            src_cr = afp_pkg::CR_RESPONSE;
        end else begin
            src_cr = afp_pkg::CR_COMMAND;
        end
    end

    // Result for the word being accepted
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.role     = afp_pkg::ROLE_DEST;
        o_res.cmd_resp = afp_pkg::CR_UNKNOWN;
        o_res.status   = afp_pkg::ST_OK;
        if (i_valid && r_phase == afp_pkg::PH_HEADER) begin
            if (!ssid_word) begin
                // Frame ends inside an address
                o_res_valid    = i_frame_end;
                o_res.cmd_resp = r_cmd_resp_held;
                o_res.status   = afp_pkg::ST_SHORT;
            end else begin
                o_res_valid        = 1'b1;
                o_res.callsign_raw = r_callsign_shift;
                o_res.ssid_byte    = i_data_byte;
                o_res.header_done  = done;
                if (done) begin
                    o_res.address_count = r_address_number + 1'b1;
                end
                if (r_address_number == '0) begin
                    o_res.role = afp_pkg::ROLE_DEST;
                end else if (r_address_number == afp_pkg::ADDR_NW'(1)) begin
                    o_res.role     = afp_pkg::ROLE_SRC;
                    o_res.cmd_resp = src_cr;
                end else begin
                    o_res.role       = afp_pkg::ROLE_DIGI;
                    o_res.digi_index = 3'(r_address_number - afp_pkg::ADDR_NW'(2));
                    o_res.cmd_resp   = r_cmd_resp_held;
                end
                if (r_address_number >= afp_pkg::ADDR_NW'(2) && too_many) begin
                    o_res.status = afp_pkg::ST_TOO_MANY;
                end else if (i_frame_end && !done) begin
                    o_res.status = afp_pkg::ST_SHORT;
                end
            end
        end
    end

    // Next state
    always_comb begin
        n_byte_position  = r_byte_position;
        n_address_number = r_address_number;
        n_callsign_shift = r_callsign_shift;
        n_dest_c_bit     = r_dest_c_bit;
        n_cmd_resp_held  = r_cmd_resp_held;
        n_phase          = r_phase;
        if (i_valid) begin
            if (i_frame_end) begin
                // Every frame end restarts the parser
                n_byte_position  = '0;
                n_address_number = '0;
                n_callsign_shift = '0;
                n_dest_c_bit     = 1'b0;
                n_cmd_resp_held  = afp_pkg::CR_UNKNOWN;
                n_phase          = afp_pkg::PH_HEADER;
            end else if (r_phase == afp_pkg::PH_HEADER) begin
                if (!ssid_word) begin
                    n_callsign_shift = shifted;
                    n_byte_position  = r_byte_position + 1'b1;
                end else begin
                    if (r_address_number == '0) begin
                        n_dest_c_bit = i_data_byte[afp_pkg::C_BIT];
                    end else if (r_address_number == afp_pkg::ADDR_NW'(1)) begin
                        n_cmd_resp_held = src_cr;
                    end
                    if (done || (r_address_number >= afp_pkg::ADDR_NW'(2) && too_many))
                    begin
                        n_phase = afp_pkg::PH_SKIP;
                    end else begin
                        n_address_number = r_address_number + 1'b1;
                        n_byte_position  = '0;
                        n_callsign_shift = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position  <= '0;
            r_address_number <= '0;
            r_callsign_shift <= '0;
            r_dest_c_bit     <= 1'b0;
            r_cmd_resp_held  <= afp_pkg::CR_UNKNOWN;
            r_phase          <= afp_pkg::PH_HEADER;
        end else begin
            r_byte_position  <= n_byte_position;
            r_address_number <= n_address_number;
            r_callsign_shift <= n_callsign_shift;
            r_dest_c_bit     <= n_dest_c_bit;
            r_cmd_resp_held  <= n_cmd_resp_held;
            r_phase          <= n_phase;
        end
    end

    // Checks
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_position <= afp_pkg::ADDR_LEN)
        else $error("byte position past SSID byte");
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_address_number <= LAST_ADDR)
        else $error("address number past digipeater limit");
    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == afp_pkg::PH_SKIP |-> !o_res_valid)
        else $error("result while skipping payload");
    a_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_frame_end |=> r_byte_position == '0 && r_address_number == '0)
        else $error("parser not restarted after frame end");

endmodule

// ===== src/address_field_parser.sv =====
// A result word is registered in the output register, or in the skid stage while the master side stalls.
// Throughput: one byte per cycle; the output register plus one skid stage keep the
// slave side open while a result waits, so a byte is refused only when both are full.
// Reset (i_rst_n low, synchronous): parser restarts at the destination, outputs empty.
// Top level of the address field parser; depends on afp_pkg and afp_core.
module address_field_parser #(
    parameter int MAX_DIGIS = afp_pkg::MAX_DIGIS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // tdata: [7:0] data_byte
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [7:0]                   i_s_tdata,
    input  logic                         i_s_tlast,   // frame_end
    // tdata: [47:0] callsign_raw, [55:48] ssid_byte, [57:56] role,
    //        [60:58] digi_index, [62:61] cmd_resp, [63] header_done,
    //        [67:64] address_count, [69:68] status, [71:70] zero
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [afp_pkg::TDATA_W-1:0]  o_m_tdata
);

    logic             accept;
    logic             res_valid;
    afp_pkg::t_result res;

    logic             r_out_valid, n_out_valid;
    afp_pkg::t_result r_out, n_out;
    logic             r_skid_valid, n_skid_valid;
    afp_pkg::t_result r_skid, n_skid;

    assign o_s_tready = !r_skid_valid;
    assign accept     = i_s_tvalid && o_s_tready;

    afp_core #(
        .MAX_DIGIS (MAX_DIGIS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_data_byte (i_s_tdata),
        .i_frame_end (i_s_tlast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register with skid stage
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = res_valid;
                n_out       = res;
            end
        end else if (res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // Pack result word, first field lowest
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00,
                         r_out.status,
                         r_out.address_count,
                         r_out.header_done,
                         r_out.cmd_resp,
                         r_out.digi_index,
                         r_out.role,
                         r_out.ssid_byte,
                         r_out.callsign_raw};

    // Checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with output register empty");
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready && res_valid |=> r_skid_valid)
        else $error("stalled result word dropped");
    a_no_fill_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !res_valid)
        else $error("result produced with skid stage full");

endmodule
